>>> rtl/sle_pkg.sv
// shared types and codes for the sequential list engine
package sle_pkg;

  localparam logic [2:0] REQ_APPEND = 3'd0;
  localparam logic [2:0] REQ_MODIFY = 3'd1;
  localparam logic [2:0] REQ_REMOVE = 3'd2;
  localparam logic [2:0] REQ_READ   = 3'd3;
  localparam logic [2:0] REQ_SEARCH = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_BADPOS   = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  localparam logic [7:0] SPACE_CHAR = 8'd32;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] read_value;
    logic [3:0] found_index;
    logic [4:0] count;
  } res_t;

endpackage

>>> rtl/sle_out_stage.sv
// output register stage that decouples the engine from a stalling receiver
module sle_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sle_pkg::res_t in_res,
  output logic          out_valid,
  input  logic          out_ready,
  output sle_pkg::res_t out_res
);

  logic          valid_r;
  sle_pkg::res_t res_r;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      res_r <= in_res;
    end
  end

endmodule

>>> rtl/sequential_list_engine.sv
// sequential list engine: ordered byte list held in a slot memory with a fill count
//
// Input channel (in_valid/in_ready) takes one request transaction: req_type,
// position and element. Result channel (out_valid/out_ready) returns exactly one
// transaction per request: status, read_value, found_index and the count after
// the request. Requests are handled one at a time.
// Append, modify, error cases, removing the last element and unknown types go
// straight to the result state; read passes through S_READ; search reads one slot
// at a time in S_SCAN until a match or the list end; any other remove pulls each
// later slot down one place in S_SHIFT.
// The next request is taken in the cycle after a result enters the output register,
// so a new append is not taken until the previous result has entered that register.
// The slot memory has one read and one write port with a registered read, so
// search scans and remove moves one slot per cycle.
// A result waits in an output register while out_ready is low; the next request
// is taken meanwhile, and its result is held back until that register drains.
// Reset (rst_n low, synchronous) empties the list; slot contents are not cleared
// and need no clearing pass since only slots below the count are ever read.
module sequential_list_engine #(
  parameter int CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_req_type,
  input  logic [3:0] in_position,
  input  logic [7:0] in_element,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_status,
  output logic [7:0] out_read_value,
  output logic [3:0] out_found_index,
  output logic [4:0] out_count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > 4) ? CW : 4) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_SHIFT,
    S_EMIT
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [7:0]    elem_r, elem_nxt;
  sle_pkg::res_t res_r, res_nxt;

  logic [7:0]    slots_r [CAPACITY];
  logic [7:0]    rd_data_r;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  logic          res_valid;
  logic          res_ready;
  sle_pkg::res_t stage_in;
  sle_pkg::res_t stage_out;

  logic          is_empty;
  logic          bad_pos;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] ptr_x;
  logic [XW-1:0] count_x;

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_EMIT);

  assign pos_x    = XW'(in_position);
  assign ptr_x    = XW'(ptr_r);
  assign count_x  = XW'(count_r);
  assign is_empty = (count_r == '0);
  assign bad_pos  = (pos_x >= count_x);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ptr_nxt   = ptr_r;
    elem_nxt  = elem_r;
    res_nxt   = res_r;
    wr_en     = 1'b0;
    wr_addr   = ptr_r;
    wr_data   = rd_data_r;
    rd_en     = 1'b0;
    rd_addr   = ptr_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          elem_nxt            = in_element;
          res_nxt.status      = sle_pkg::ST_OK;
          res_nxt.read_value  = 8'd0;
          res_nxt.found_index = 4'd0;
          res_nxt.count       = 5'd0;
          state_nxt           = S_EMIT;
          case (in_req_type)
            sle_pkg::REQ_APPEND: begin
              if (count_x >= XW'(CAPACITY)) begin
                res_nxt.status = sle_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = AW'(count_r);
                wr_data   = in_element;
                count_nxt = count_r + 1'b1;
              end
            end
            sle_pkg::REQ_MODIFY: begin
              if (is_empty) begin
                res_nxt.status = sle_pkg::ST_EMPTY;
              end else if (bad_pos) begin
                res_nxt.status = sle_pkg::ST_BADPOS;
              end else begin
                wr_en   = 1'b1;
                wr_addr = AW'(in_position);
                wr_data = in_element;
              end
            end
            sle_pkg::REQ_REMOVE: begin
              if (is_empty) begin
                res_nxt.status = sle_pkg::ST_EMPTY;
              end else if (bad_pos) begin
                res_nxt.status = sle_pkg::ST_BADPOS;
              end else if (pos_x + XW'(1) < count_x) begin
                // fetch the slot after the gap, write it down next cycle
                rd_en     = 1'b1;
                rd_addr   = AW'(in_position) + AW'(1);
                ptr_nxt   = AW'(in_position);
                state_nxt = S_SHIFT;
              end else begin
                count_nxt = count_r - 1'b1;
              end
            end
            sle_pkg::REQ_READ: begin
              if (is_empty) begin
                res_nxt.status     = sle_pkg::ST_EMPTY;
                res_nxt.read_value = sle_pkg::SPACE_CHAR;
              end else if (bad_pos) begin
                res_nxt.status     = sle_pkg::ST_BADPOS;
                res_nxt.read_value = sle_pkg::SPACE_CHAR;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = AW'(in_position);
                state_nxt = S_READ;
              end
            end
            sle_pkg::REQ_SEARCH: begin
              if (is_empty) begin
                res_nxt.status = sle_pkg::ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                ptr_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              res_nxt.status = sle_pkg::ST_OK;
            end
          endcase
        end
      end
      S_READ: begin
        res_nxt.read_value = rd_data_r;
        state_nxt          = S_EMIT;
      end
      S_SCAN: begin
        if (rd_data_r == elem_r) begin
          res_nxt.found_index = 4'(ptr_r);
          state_nxt           = S_EMIT;
        end else if (ptr_x + XW'(1) < count_x) begin
          rd_en   = 1'b1;
          rd_addr = ptr_r + AW'(1);
          ptr_nxt = ptr_r + AW'(1);
        end else begin
          res_nxt.status = sle_pkg::ST_NOTFOUND;
          state_nxt      = S_EMIT;
        end
      end
      S_SHIFT: begin
        // rd_data_r holds slot ptr+1
        wr_en   = 1'b1;
        wr_addr = ptr_r;
        wr_data = rd_data_r;
        if (ptr_x + XW'(2) < count_x) begin
          rd_en   = 1'b1;
          rd_addr = ptr_r + AW'(2);
          ptr_nxt = ptr_r + AW'(1);
        end else begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r  <= ptr_nxt;
    elem_r <= elem_nxt;
    res_r  <= res_nxt;
  end

  // slot memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= slots_r[rd_addr];
    end
  end

  always_comb begin
    stage_in       = res_r;
    stage_in.count = 5'(count_r);
  end

  sle_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (res_valid),
    .in_ready  (res_ready),
    .in_res    (stage_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (stage_out)
  );

  assign out_status      = stage_out.status;
  assign out_read_value  = stage_out.read_value;
  assign out_found_index = stage_out.found_index;
  assign out_count       = stage_out.count;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_x <= XW'(CAPACITY))
    else $error("fill count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == $past(count_r)) || (count_r == $past(count_r) + 1'b1) ||
    (count_r == $past(count_r) - 1'b1))
    else $error("fill count moved by more than one");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (ptr_x < count_x))
    else $error("search pointer beyond list end");

  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (ptr_x + XW'(1) < count_x))
    else $error("remove shift beyond list end");

  a_no_write_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) || (state_r == S_READ) || (state_r == S_EMIT)) |-> !wr_en)
    else $error("slot write outside append, modify or remove");

endmodule

>>> test/list_result_checker.sv
// checker for the sequential list engine: mirrors the list, predicts and compares results
module list_result_checker #(
  parameter int CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [2:0] in_req_type,
  input  logic [3:0] in_position,
  input  logic [7:0] in_element,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [2:0] out_status,
  input  logic [7:0] out_read_value,
  input  logic [3:0] out_found_index,
  input  logic [4:0] out_count,
  output int         fail_count,
  output int         outstanding
);

  logic [7:0]    mirror_slots [CAPACITY];
  int            mirror_len;
  sle_pkg::res_t pending_results [$];
  sle_pkg::res_t oldest;

  // updates the mirrored list and returns the result the request must produce
  function automatic sle_pkg::res_t apply_request(logic [2:0] kind, logic [3:0] pos,
                                                  logic [7:0] elem);
    sle_pkg::res_t r;
    int   p;
    int   i;
    bit   hit;
    r = '0;
    r.status = sle_pkg::ST_OK;
    p = int'(pos);
    hit = 1'b0;
    case (kind)
      sle_pkg::REQ_APPEND: begin
        if (mirror_len >= CAPACITY) begin
          r.status = sle_pkg::ST_FULL;
        end else begin
          mirror_slots[mirror_len] = elem;
          mirror_len++;
        end
      end
      sle_pkg::REQ_MODIFY: begin
        if (mirror_len == 0) r.status = sle_pkg::ST_EMPTY;
        else if (p >= mirror_len) r.status = sle_pkg::ST_BADPOS;
        else mirror_slots[p] = elem;
      end
      sle_pkg::REQ_REMOVE: begin
        if (mirror_len == 0) begin
          r.status = sle_pkg::ST_EMPTY;
        end else if (p >= mirror_len) begin
          r.status = sle_pkg::ST_BADPOS;
        end else begin
          // close the gap by pulling later elements down
          for (i = p; i + 1 < mirror_len; i++) mirror_slots[i] = mirror_slots[i + 1];
          mirror_len--;
        end
      end
      sle_pkg::REQ_READ: begin
        if (mirror_len == 0) begin
          r.status = sle_pkg::ST_EMPTY;
          r.read_value = sle_pkg::SPACE_CHAR;
        end else if (p >= mirror_len) begin
          r.status = sle_pkg::ST_BADPOS;
          r.read_value = sle_pkg::SPACE_CHAR;
        end else begin
          r.read_value = mirror_slots[p];
        end
      end
      sle_pkg::REQ_SEARCH: begin
        if (mirror_len == 0) begin
          r.status = sle_pkg::ST_EMPTY;
        end else begin
          r.status = sle_pkg::ST_NOTFOUND;
          for (i = 0; i < mirror_len; i++) begin
            if (!hit && mirror_slots[i] == elem) begin
              hit = 1'b1;
              r.status = sle_pkg::ST_OK;
              r.found_index = 4'(i);
            end
          end
        end
      end
      default: begin
        // reserved request types leave the list alone
      end
    endcase
    r.count = 5'(mirror_len);
    return r;
  endfunction

  task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pending_results.delete();
      mirror_len = 0;
      fail_count = 0;
    end else begin
      // a result never belongs to a request taken at the same edge, so compare first
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none, actual status %0d count %0d",
                   $time, out_status, out_count);
          fail_count++;
        end else begin
          oldest = pending_results.pop_front();
          check_field("status", 8'(oldest.status), 8'(out_status));
          check_field("read_value", oldest.read_value, out_read_value);
          check_field("found_index", 8'(oldest.found_index), 8'(out_found_index));
          check_field("count", 8'(oldest.count), 8'(out_count));
        end
      end
      if (in_valid && in_ready) begin
        pending_results.push_back(apply_request(in_req_type, in_position, in_element));
      end
    end
    outstanding = pending_results.size();
  end

endmodule

>>> test/tb_sequential_list_engine.sv
// testbench top for the sequential list engine: stimulus, flow control and verdict
module tb_sequential_list_engine;

  localparam int          LIST_CAP        = 16;
  localparam logic [2:0]  REQ_RSVD_FIRST  = 3'd5;
  localparam logic [2:0]  REQ_RSVD_LAST   = 3'd7;
  localparam int          RANDOM_ITEMS    = 1000;
  localparam int          PRESSURE_AT     = 300;
  localparam int          PRESSURE_CYCLES = 400;
  localparam int          DRAIN_CYCLES    = 2 * LIST_CAP + 8;
  localparam int          CYCLE_LIMIT     = 500000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] in_req_type = '0;
  logic [3:0] in_position = '0;
  logic [7:0] in_element = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_status;
  logic [7:0] out_read_value;
  logic [3:0] out_found_index;
  logic [4:0] out_count;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  int items_sent = 0;
  int list_len = 0;
  bit no_idle = 1'b0;

  always #5 clk = ~clk;

  sequential_list_engine #(
    .CAPACITY(LIST_CAP)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req_type(in_req_type),
    .in_position(in_position),
    .in_element(in_element),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_read_value(out_read_value),
    .out_found_index(out_found_index),
    .out_count(out_count)
  );

  list_result_checker #(
    .CAPACITY(LIST_CAP)
  ) i_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req_type(in_req_type),
    .in_position(in_position),
    .in_element(in_element),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_read_value(out_read_value),
    .out_found_index(out_found_index),
    .out_count(out_count),
    .fail_count(fail_count),
    .outstanding(outstanding)
  );

  // mostly short idle gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic send_request(input logic [2:0] kind, input logic [3:0] pos,
                              input logic [7:0] elem);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= kind;
    in_position <= pos;
    in_element  <= elem;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    // rough list length, only used to aim positions
    if (kind == sle_pkg::REQ_APPEND && list_len < LIST_CAP) list_len++;
    if (kind == sle_pkg::REQ_REMOVE && int'(pos) < list_len) list_len--;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL sequential_list_engine");
      $finish;
    end
  end

  // result side flow control, with one long hold-off to back the block up
  initial begin
    int  run_left;
    int  stall_left;
    bit  pressure_done;
    int  g;
    run_left = 0;
    stall_left = 0;
    pressure_done = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!pressure_done && items_sent >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        stall_left = PRESSURE_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (no_idle) begin
        out_ready <= 1'b1;
      end else if (run_left > 0) begin
        run_left--;
      end else if (out_ready) begin
        g = pick_gap();
        if (g > 0) begin
          out_ready <= 1'b0;
          run_left = g - 1;
        end else begin
          run_left = $urandom_range(12);
        end
      end else begin
        out_ready <= 1'b1;
        run_left = $urandom_range(12);
      end
    end
  end

  initial begin
    int         i;
    int         n;
    int         roll;
    bit         grow;
    logic [2:0] kind;
    logic [3:0] pos;
    logic [7:0] elem;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list cases and a reserved type
    send_request(sle_pkg::REQ_READ, 4'd0, 8'd0);
    send_request(sle_pkg::REQ_MODIFY, 4'd0, 8'hFF);
    send_request(sle_pkg::REQ_REMOVE, 4'd15, 8'd0);
    send_request(sle_pkg::REQ_SEARCH, 4'd0, 8'd0);
    send_request(REQ_RSVD_LAST, 4'd15, 8'hFF);
    // fill to capacity, then one append too many
    for (i = 0; i < LIST_CAP; i++) send_request(sle_pkg::REQ_APPEND, 4'(i), 8'(i * 17));
    send_request(sle_pkg::REQ_APPEND, 4'd0, 8'h5A);
    send_request(sle_pkg::REQ_SEARCH, 4'd0, 8'hFF);
    send_request(sle_pkg::REQ_SEARCH, 4'd0, 8'h01);
    send_request(sle_pkg::REQ_REMOVE, 4'd15, 8'd0);
    send_request(sle_pkg::REQ_REMOVE, 4'd0, 8'd0);
    send_request(sle_pkg::REQ_READ, 4'd14, 8'd0);
    send_request(sle_pkg::REQ_MODIFY, 4'd13, 8'hA5);
    send_request(sle_pkg::REQ_READ, 4'd13, 8'd0);
    send_request(sle_pkg::REQ_READ, 4'd0, 8'd0);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= 600 && n < 750);
      // alternate growing and shrinking phases so the list sweeps empty to full
      grow = ((n / 64) % 2) == 0;
      roll = $urandom_range(99);
      if (roll < 3) kind = 3'($urandom_range(REQ_RSVD_LAST, REQ_RSVD_FIRST));
      else if (roll < (grow ? 40 : 15)) kind = sle_pkg::REQ_APPEND;
      else if (roll < (grow ? 52 : 50)) kind = sle_pkg::REQ_REMOVE;
      else if (roll < 68) kind = sle_pkg::REQ_MODIFY;
      else if (roll < 84) kind = sle_pkg::REQ_READ;
      else kind = sle_pkg::REQ_SEARCH;
      if (list_len > 0 && $urandom_range(9) < 8) pos = 4'($urandom_range(list_len - 1));
      else pos = 4'($urandom_range(15));
      // a small pool of values makes searches hit often
      if ($urandom_range(1) == 0) elem = 8'($urandom_range(7));
      else elem = 8'($urandom_range(255));
      send_request(kind, pos, elem);
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    // let the checker record the last transaction before looking at the backlog
    @(posedge clk);
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS sequential_list_engine");
    end else begin
      $display("FAIL sequential_list_engine");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/sle_pkg.sv
rtl/sle_out_stage.sv
rtl/sequential_list_engine.sv
test/list_result_checker.sv
test/tb_sequential_list_engine.sv
